// ----- hw/rtl/pfx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, character codes and status codes of the postfix evaluator.
package pfx_pkg;

  localparam int WORD_W   = 32;
  localparam int SYM_W    = 8;
  localparam int STATUS_W = 3;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [SYM_W-1:0]    sym_t;
  typedef logic [STATUS_W-1:0] status_t;

  // ASCII codes
  localparam sym_t ASCII_0 = 8'd48;
  localparam sym_t ASCII_9 = 8'd57;
  localparam sym_t OP_ADD  = 8'd43;
  localparam sym_t OP_SUB  = 8'd45;
  localparam sym_t OP_MUL  = 8'd42;
  localparam sym_t OP_DIV  = 8'd47;

  // Result status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_UNDERFLOW = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_DIVZERO   = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

  // Divider request and response
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_resp_t;

endpackage

// ----- hw/rtl/pfx_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for symbol requests and evaluation results.
interface pfx_sym_if;
  logic        valid;
  logic        ready;
  pfx_pkg::sym_t symbol;
  logic        last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfx_res_if;
  logic              valid;
  logic              ready;
  pfx_pkg::word_t    value;
  pfx_pkg::status_t  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- hw/rtl/pfx_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/pfx_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
module pfx_div (
  input  logic               clk,
  input  logic               rst,
  input  pfx_pkg::div_req_t  req,
  output pfx_pkg::div_resp_t resp
);

  localparam int W     = pfx_pkg::WORD_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic             neg;

  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend[W-1] ? -req.dividend : req.dividend;
        dvs  <= req.divisor[W-1] ? -req.divisor : req.divisor;
        neg  <= req.dividend[W-1] ^ req.divisor[W-1];
      end else if (busy) begin
        // keep the partial remainder when the trial subtract goes negative
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= shifted[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.done     = done;
  assign resp.quotient = neg ? -quo : quo;

endmodule

// ----- hw/rtl/postfix_expression_evaluator_core.sv -----
`timescale 1ns / 1ps
// Postfix expression evaluator top level: stack control, ALU and result register.
//
// Usage:
//   symbols carries one postfix character per request (symbol, last).
//   Digits push, + - * / pop two operands and push the result, anything
//   else is ignored. The request with last set closes the expression.
//   results carries one request per expression: top of stack and status
//   (0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 empty).
// Sequencing:
//   The block handles one symbol at a time. A digit or an ignored character
//   is handled on acceptance; + - * read the stack RAM, then write back,
//   and / reads the RAM, loads the divider operands, waits for the radix-2
//   divider, then writes back, or writes back zero when the divisor is zero.
//   The last symbol then loads the result register.
// Stall:
//   The result register holds until taken. New symbols are accepted while
//   a result waits; only the next closing symbol stalls until it is free.
// Reset:
//   rst clears the stack count, the sticky error and the result valid.
//   The stack RAM needs no clearing: only entries below the count are read.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  pfx_sym_if.sink   symbols,
  pfx_res_if.source results
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  // Controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  pfx_pkg::status_t sticky, sticky_next;
  pfx_pkg::word_t   tos, tos_next;      // copy of the top entry
  pfx_pkg::word_t   b_reg, b_next;      // right operand
  pfx_pkg::sym_t    op, op_next;
  logic             last_reg, last_next;

  logic             out_valid;
  pfx_pkg::word_t   out_value;
  pfx_pkg::status_t out_status;
  logic             out_free;
  logic             out_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  pfx_pkg::word_t     ram_wdata;
  logic               ram_re;
  pfx_pkg::word_t     ram_rdata;

  pfx_pkg::div_req_t  div_req;
  pfx_pkg::div_resp_t div_resp;

  logic               accept;
  logic               is_digit;
  logic               is_op;
  pfx_pkg::word_t     digit_val;
  logic [CNT_W-1:0]   count_m2;
  logic [ADDR_W-1:0]  top_addr;   // address of entry a (count - 2)
  logic [ADDR_W-1:0]  push_addr;
  pfx_pkg::word_t     alu;

  function automatic pfx_pkg::status_t note_error(input pfx_pkg::status_t cur,
                                                  input pfx_pkg::status_t code);
    return (cur == pfx_pkg::ST_OK) ? code : cur;
  endfunction

  pfx_ram #(
    .WIDTH (pfx_pkg::WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (top_addr),
    .rdata (ram_rdata)
  );

  pfx_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign symbols.ready = (state == S_IDLE);
  assign accept        = symbols.valid && symbols.ready;

  assign is_digit  = (symbols.symbol >= pfx_pkg::ASCII_0) &&
                     (symbols.symbol <= pfx_pkg::ASCII_9);
  assign is_op     = (symbols.symbol == pfx_pkg::OP_ADD) ||
                     (symbols.symbol == pfx_pkg::OP_SUB) ||
                     (symbols.symbol == pfx_pkg::OP_MUL) ||
                     (symbols.symbol == pfx_pkg::OP_DIV);
  assign digit_val = {{(pfx_pkg::WORD_W - pfx_pkg::SYM_W){1'b0}},
                      symbols.symbol - pfx_pkg::ASCII_0};

  assign count_m2  = count - CNT_W'(2);
  assign top_addr  = count_m2[ADDR_W-1:0];
  assign push_addr = count[ADDR_W-1:0];

  // a comes straight from the RAM read register, b from the cached top
  always_comb begin
    unique case (op)
      pfx_pkg::OP_ADD: alu = ram_rdata + b_reg;
      pfx_pkg::OP_SUB: alu = ram_rdata - b_reg;
      default:         alu = ram_rdata * b_reg;
    endcase
  end

  assign out_free = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    count_next = count;
    sticky_next = sticky;
    tos_next   = tos;
    b_next     = b_reg;
    op_next    = op;
    last_next  = last_reg;
    ram_we     = 1'b0;
    ram_waddr  = top_addr;
    ram_wdata  = alu;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = ram_rdata;
    div_req.divisor  = b_reg;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          last_next  = symbols.last;
          op_next    = symbols.symbol;
          b_next     = tos;
          state_next = symbols.last ? S_FIN : S_IDLE;
          if (is_digit) begin
            if (count == CNT_W'(STACK_DEPTH)) begin
              // full stack: drop the digit
              sticky_next = note_error(sticky, pfx_pkg::ST_OVERFLOW);
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = push_addr;
              ram_wdata  = digit_val;
              tos_next   = digit_val;
              count_next = count + 1'b1;
            end
          end else if (is_op) begin
            if (count < CNT_W'(2)) begin
              sticky_next = note_error(sticky, pfx_pkg::ST_UNDERFLOW);
            end else begin
              ram_re     = 1'b1;
              state_next = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (op == pfx_pkg::OP_DIV) begin
          if (b_reg == '0) begin
            // pop both, push zero
            sticky_next = note_error(sticky, pfx_pkg::ST_DIVZERO);
            ram_we      = 1'b1;
            ram_wdata   = '0;
            tos_next    = '0;
            count_next  = count - 1'b1;
            state_next  = last_reg ? S_FIN : S_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          ram_we     = 1'b1;
          tos_next   = alu;
          count_next = count - 1'b1;
          state_next = last_reg ? S_FIN : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_resp.done) begin
          ram_we     = 1'b1;
          ram_wdata  = div_resp.quotient;
          tos_next   = div_resp.quotient;
          count_next = count - 1'b1;
          state_next = last_reg ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // hold until the result register is free, then clear the stack
        if (out_free) begin
          out_load    = 1'b1;
          count_next  = '0;
          sticky_next = pfx_pkg::ST_OK;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sticky    <= pfx_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      sticky <= sticky_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos      <= tos_next;
    b_reg    <= b_next;
    op       <= op_next;
    last_reg <= last_next;
    if (out_load) begin
      out_value  <= (count != '0) ? tos : '0;
      if (sticky != pfx_pkg::ST_OK) begin
        out_status <= sticky;
      end else if (count == '0) begin
        out_status <= pfx_pkg::ST_EMPTY;
      end else begin
        out_status <= pfx_pkg::ST_OK;
      end
    end
  end

  assign results.valid  = out_valid;
  assign results.value  = out_value;
  assign results.status = out_status;

`ifndef SYNTHESIS
  // RAM port is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("stack RAM read and write in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=>
      (count == '0 && sticky == pfx_pkg::ST_OK && results.valid))
    else $error("end of expression did not clear stack or load result");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_resp.done |-> (state == S_DIV))
    else $error("divider finished outside divide wait");
`endif

endmodule
